// File: hdl/mnp_pkg.sv
// Shared types, message codes and the note period table for the MIDI note parser.
// No dependencies; imported by mnp_parser, mnp_out and midi_note_parser.
`timescale 1ns / 1ps

package mnp_pkg;

    localparam int NOTE_TABLE_DEPTH_DEF = 128;
    localparam int PERIOD_W = 16;
    localparam int BYTE_W = 8;
    localparam int DATA_W = 7;
    localparam int M_TDATA_W = 24;

    localparam logic [BYTE_W-1:0] STATUS_NOTE_OFF = 8'h80;
    localparam logic [BYTE_W-1:0] STATUS_NOTE_ON = 8'h90;
    localparam logic [BYTE_W-1:0] STATUS_ACTIVE_SENSE = 8'hFE;
    localparam logic [BYTE_W-1:0] STATUS_STOP = 8'hFC;
    localparam logic [BYTE_W-1:0] STATUS_RESET = 8'hFF;

    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_OFF = 2'd1;
    localparam logic [1:0] KIND_ON = 2'd2;

    localparam logic [1:0] PAIR_LEN = 2'd2;
    localparam logic [BYTE_W-1:0] NO_NOTE = 8'hFF;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd440;

    typedef struct packed {
        logic load;
        logic gate;
        logic active;
    } mnp_step_t;

    localparam logic [PERIOD_W-1:0] NOTE_PERIODS [0:NOTE_TABLE_DEPTH_DEF-1] = '{
        16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd64865, 16'd61224,
        16'd57788, 16'd54544, 16'd51483, 16'd48593, 16'd45866, 16'd43292, 16'd40862, 16'd38568,
        16'd36404, 16'd34360, 16'd32432, 16'd30612, 16'd28893, 16'd27272, 16'd25741, 16'd24296,
        16'd22933, 16'd21645, 16'd20430, 16'd19284, 16'd18201, 16'd17180, 16'd16215, 16'd15305,
        16'd14446, 16'd13635, 16'd12870, 16'd12148, 16'd11466, 16'd10822, 16'd10215, 16'd9641,
        16'd9100, 16'd8589, 16'd8107, 16'd7652, 16'd7223, 16'd6817, 16'd6435, 16'd6073,
        16'd5732, 16'd5411, 16'd5107, 16'd4820, 16'd4550, 16'd4294, 16'd4053, 16'd3826,
        16'd3611, 16'd3408, 16'd3217, 16'd3036, 16'd2866, 16'd2705, 16'd2553, 16'd2410,
        16'd2274, 16'd2147, 16'd2026, 16'd1912, 16'd1805, 16'd1704, 16'd1608, 16'd1518,
        16'd1432, 16'd1352, 16'd1276, 16'd1204, 16'd1137, 16'd1073, 16'd1013, 16'd956,
        16'd902, 16'd851, 16'd803, 16'd758, 16'd716, 16'd675, 16'd637, 16'd602,
        16'd568, 16'd536, 16'd506, 16'd477, 16'd450, 16'd425, 16'd401, 16'd379,
        16'd357, 16'd337, 16'd318, 16'd300, 16'd283, 16'd267, 16'd252, 16'd238,
        16'd225, 16'd212, 16'd200, 16'd189, 16'd178, 16'd168, 16'd159, 16'd150,
        16'd141, 16'd133, 16'd126, 16'd119, 16'd112, 16'd106, 16'd100, 16'd94,
        16'd89, 16'd84, 16'd79, 16'd74, 16'd70, 16'd66, 16'd62, 16'd59
    };

endpackage

// File: hdl/mnp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module mnp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/mnp_parser.sv
// MIDI byte decoder: message mode, running status, data pair, held note and flags.
// Depends on mnp_pkg; drives the note table read address.
`timescale 1ns / 1ps

module mnp_parser
    import mnp_pkg::*;
#(
    parameter int NOTE_TABLE_DEPTH = NOTE_TABLE_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                byte_accept,
    input  logic [BYTE_W-1:0]                   rx_byte,
    output mnp_step_t                           step,
    output logic [$clog2(NOTE_TABLE_DEPTH)-1:0] rom_addr
);

    localparam int ADDR_W = $clog2(NOTE_TABLE_DEPTH);

    logic [1:0]        kind_reg, kind_next;
    logic [1:0]        remain_reg, remain_next;
    logic [DATA_W-1:0] pair0_reg, pair0_next;
    logic [DATA_W-1:0] pair1_reg, pair1_next;
    logic [BYTE_W-1:0] held_reg, held_next;
    logic              gate_reg, gate_next;
    logic              active_reg, active_next;
    logic              load;
    logic              release_note;

    always_comb begin
        kind_next = kind_reg;
        remain_next = remain_reg;
        pair0_next = pair0_reg;
        pair1_next = pair1_reg;
        held_next = held_reg;
        gate_next = gate_reg;
        active_next = active_reg;
        load = 1'b0;
        release_note = 1'b0;
        if (rx_byte[BYTE_W-1]) begin
            active_next = 1'b1;
            if (rx_byte == STATUS_NOTE_OFF) begin
                kind_next = KIND_OFF;
                remain_next = PAIR_LEN;
            end else if (rx_byte == STATUS_NOTE_ON) begin
                kind_next = KIND_ON;
                remain_next = PAIR_LEN;
            end else if (rx_byte != STATUS_ACTIVE_SENSE) begin
                if (rx_byte == STATUS_STOP || rx_byte == STATUS_RESET) begin
                    gate_next = 1'b0;
                end
                kind_next = KIND_OTHER;
                remain_next = 2'd0;
            end
        end else begin
            if (remain_reg != 2'd0) begin
                pair0_next = pair1_reg;
                pair1_next = rx_byte[DATA_W-1:0];
                remain_next = remain_reg - 2'd1;
            end
            if (remain_next == 2'd0) begin
                case (kind_reg)
                    KIND_OFF: begin
                        release_note = 1'b1;
                        remain_next = PAIR_LEN;
                    end
                    KIND_ON: begin
                        if (pair1_next == '0) begin
                            release_note = 1'b1;
                        end else begin
                            gate_next = 1'b1;
                            load = 1'b1;
                            held_next = {1'b0, pair0_next};
                        end
                        remain_next = PAIR_LEN;
                    end
                    default: begin
                    end
                endcase
            end
            if (release_note && ({1'b0, pair0_next} == held_reg)) begin
                gate_next = 1'b0;
                held_next = NO_NOTE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg <= KIND_OTHER;
            remain_reg <= 2'd0;
            pair0_reg <= '0;
            pair1_reg <= '0;
            held_reg <= NO_NOTE;
            gate_reg <= 1'b1;
            active_reg <= 1'b0;
        end else if (byte_accept) begin
            kind_reg <= kind_next;
            remain_reg <= remain_next;
            pair0_reg <= pair0_next;
            pair1_reg <= pair1_next;
            held_reg <= held_next;
            gate_reg <= gate_next;
            active_reg <= active_next;
        end
    end

    assign step.load = load;
    assign step.gate = gate_next;
    assign step.active = active_next;
    assign rom_addr = ADDR_W'(pair0_next);

    assert property (@(posedge aclk) disable iff (!aresetn)
        step.load |-> step.gate)
        else $error("note load without an open gate");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (kind_reg == KIND_OFF || kind_reg == KIND_ON) |-> remain_reg != 2'd0)
        else $error("note mode active with no data bytes expected");

endmodule

// File: hdl/mnp_out.sv
// Result pipeline: table-read stage, period register and the output register.
// Depends on mnp_pkg; takes the note table read data from mnp_ram.
`timescale 1ns / 1ps

module mnp_out
    import mnp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_valid,
    input  mnp_step_t            step,
    input  logic [PERIOD_W-1:0]  rom_data,
    output logic                 step_ready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic                 p1_valid_reg;
    mnp_step_t            p1_reg;
    logic [PERIOD_W-1:0]  period_reg, period_next;
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic                 p1_adv;

    assign p1_adv = p1_valid_reg && (!out_valid_reg || m_tready);
    assign step_ready = !p1_valid_reg || p1_adv;
    assign period_next = (p1_adv && p1_reg.load) ? rom_data : period_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            period_reg <= PERIOD_RESET;
        end else begin
            if (step_ready) begin
                p1_valid_reg <= step_valid;
            end
            if (p1_adv) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            period_reg <= period_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_ready && step_valid) begin
            p1_reg <= step;
        end
        if (p1_adv) begin
            out_data_reg <= {(M_TDATA_W - PERIOD_W - 2)'(0), p1_reg.active, p1_reg.gate,
                             period_next};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && !p1_adv) |=> (p1_valid_reg && $stable(p1_reg)))
        else $error("stalled table-read stage lost its word");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !(p1_adv && p1_reg.load) |=> period_reg == $past(period_reg))
        else $error("period changed without a note load");

endmodule

// File: hdl/midi_note_parser.sv
// Top level of the MIDI note parser: table load sweep, note table RAM, decoder, result stage.
// Depends on mnp_pkg, mnp_ram, mnp_parser and mnp_out.
//
//   channel | dir | tdata fields (low bit up)                               | tuser/tlast
//   s_      | in  | rx_byte[7:0]                                            | none
//   m_      | out | pitch_period[15:0], note_gate[16], midi_active[17], pad  | none
//
// One byte is accepted per cycle while s_tready is high; its result is presented after the
// registered read of the note table RAM and the output register.
// After reset the note table is loaded entry by entry from the package table; s_tready
// stays low during that sweep. After it, s_tready drops only when both the table-read
// stage and the output register hold words and m_tready is low.
`timescale 1ns / 1ps

module midi_note_parser
    import mnp_pkg::*;
#(
    parameter int NOTE_TABLE_DEPTH = NOTE_TABLE_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [BYTE_W-1:0]    s_tdata,  // rx_byte[7:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // pitch_period[15:0], note_gate, midi_active
);

    localparam int ADDR_W = $clog2(NOTE_TABLE_DEPTH);

    logic              init_busy_reg;
    logic [ADDR_W-1:0] init_addr_reg;
    logic              step_ready;
    logic              byte_accept;
    mnp_step_t         step;
    logic [ADDR_W-1:0] rom_addr;
    logic [PERIOD_W-1:0] rom_data;
    logic              rom_re;

    assign s_tready = step_ready && !init_busy_reg;
    assign byte_accept = s_tvalid && s_tready;
    assign rom_re = byte_accept && step.load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_busy_reg <= 1'b1;
            init_addr_reg <= '0;
        end else if (init_busy_reg) begin
            if (init_addr_reg == ADDR_W'(NOTE_TABLE_DEPTH - 1)) begin
                init_busy_reg <= 1'b0;
            end else begin
                init_addr_reg <= init_addr_reg + ADDR_W'(1);
            end
        end
    end

    mnp_ram #(
        .WIDTH (PERIOD_W),
        .DEPTH (NOTE_TABLE_DEPTH)
    ) u_note_ram (
        .aclk    (aclk),
        .wr_en   (init_busy_reg),
        .wr_addr (init_addr_reg),
        .wr_data (NOTE_PERIODS[init_addr_reg]),
        .rd_en   (rom_re),
        .rd_addr (rom_addr),
        .rd_data (rom_data)
    );

    mnp_parser #(
        .NOTE_TABLE_DEPTH (NOTE_TABLE_DEPTH)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (byte_accept),
        .rx_byte     (s_tdata),
        .step        (step),
        .rom_addr    (rom_addr)
    );

    mnp_out u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_valid (byte_accept),
        .step       (step),
        .rom_data   (rom_data),
        .step_ready (step_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    assert property (@(posedge aclk) disable iff (!aresetn)
        init_busy_reg |-> !rom_re)
        else $error("note table read during the load sweep");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (init_busy_reg && init_addr_reg == ADDR_W'(NOTE_TABLE_DEPTH - 1)) |=> !init_busy_reg)
        else $error("load sweep did not end after the last entry");

endmodule
